[src/aarm_pkg.sv]
// Shared definitions for the ADC average range monitor.
// Holds field widths, register indexes, range codes and parameter defaults.
// No dependencies.
package aarm_pkg;

  localparam int unsigned WINDOW_DEFAULT  = 8;
  localparam int unsigned RAW_MAX_DEFAULT = 4095;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned REF_W     = 13;
  localparam int unsigned MEAN_W    = 12;
  localparam int unsigned MV_W      = 13;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;

  localparam logic [LEVEL_W-1:0] LOW_ENTER_RESET  = 12'd100;
  localparam logic [LEVEL_W-1:0] LOW_CLEAR_RESET  = 12'd200;
  localparam logic [LEVEL_W-1:0] HIGH_ENTER_RESET = 12'd3995;
  localparam logic [LEVEL_W-1:0] HIGH_CLEAR_RESET = 12'd3895;
  localparam logic [REF_W-1:0]   REF_MV_RESET     = 13'd3300;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_ENTER  = 3'd0,
    REG_LOW_CLEAR  = 3'd1,
    REG_HIGH_ENTER = 3'd2,
    REG_HIGH_CLEAR = 3'd3,
    REG_REF_MV     = 3'd4
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2
  } mode_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[src/adc_average_range_monitor.sv]
// ADC average range monitor, top level: sequencer, configuration and range state.
// Instantiates aarm_ring and aarm_div; uses aarm_pkg.
//
// Each accepted item is one raw converter reading. It is clamped to 0..RAW_MAX,
// stored in a ring memory of WINDOW samples that keeps a running sum, and the
// truncated mean (sum divided by the number of stored samples) is reported
// together with its value in millivolts, rounded half up against the reference
// register, and a three-state range status with separate enter and clear
// thresholds. Every item gives exactly one result item. The mean comes from a
// restoring divider that produces one quotient bit per cycle over the SUMW bits
// of the running sum (clog2(RAW_MAX+1) + clog2(WINDOW+1), 16 with the defaults).
// The millivolt value is then formed in registered steps: the product with the
// reference, the half-scale rounding term, and a multiplication by a fixed
// reciprocal of RAW_MAX that yields the exact quotient. A result is held in the
// output register, and the next item is taken only once the previous result has
// been loaded there.
// A finished result waits in the output register while the next item is already
// taken and worked on; only that next result waits for it to leave. No item is
// taken during reset. Configuration writes are ready whenever reset is low and
// should be made only while the block is idle.
module adc_average_range_monitor #(
  parameter int unsigned WINDOW  = aarm_pkg::WINDOW_DEFAULT,
  parameter int unsigned RAW_MAX = aarm_pkg::RAW_MAX_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [aarm_pkg::RAW_W-1:0]  raw_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [aarm_pkg::MEAN_W-1:0]        mean_value,
  output logic [aarm_pkg::MV_W-1:0]          mean_millivolts,
  output logic [aarm_pkg::STATUS_W-1:0]      range_status,
  output logic                               out_of_range,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aarm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aarm_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import aarm_pkg::*;

  // Width of a clamped sample and of everything derived from it.
  localparam int unsigned SW    = $clog2(RAW_MAX + 1);
  localparam int unsigned CNTW  = $clog2(WINDOW + 1);
  localparam int unsigned SUMW  = SW + CNTW;
  localparam int unsigned PRODW = SW + REF_W;
  localparam int unsigned NUMW  = PRODW + 1;
  localparam int unsigned DIVW  = SUMW;
  localparam int unsigned DVW   = CNTW;
  localparam int unsigned CMPW  = (SW > LEVEL_W) ? SW : LEVEL_W;
  localparam logic [NUMW-1:0] HALF_SCALE = NUMW'(RAW_MAX / 2);

  // Reciprocal of RAW_MAX rounded up. With a shift of NUMW + SW the product
  // gives the exact quotient for every NUMW-bit numerator.
  localparam int unsigned RECIP_SHIFT = NUMW + SW;
  localparam int unsigned RECIPW      = NUMW + 2;
  localparam int unsigned SCALEDW     = NUMW + RECIPW;
  localparam logic [63:0] RECIP_FULL  =
    ((64'd1 << RECIP_SHIFT) + 64'(RAW_MAX) - 64'd1) / 64'(RAW_MAX);
  localparam logic [RECIPW-1:0] RECIP = RECIPW'(RECIP_FULL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_SCALE,
    S_ROUND,
    S_CONVERT,
    S_OUTPUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LEVEL_W-1:0] low_enter_level;
  logic [LEVEL_W-1:0] low_clear_level;
  logic [LEVEL_W-1:0] high_enter_level;
  logic [LEVEL_W-1:0] high_clear_level;
  logic [REF_W-1:0]   reference_millivolts;

  // Per-item working registers.
  logic [SW-1:0]    sample;
  logic [SW-1:0]    mean;
  logic [PRODW-1:0] product;
  logic [NUMW-1:0]  numerator;
  logic [MV_W-1:0]  millivolts;
  mode_t            range_mode;

  // Ring and divider connections.
  logic             ring_update;
  logic [SUMW-1:0]  ring_sum;
  logic [CNTW-1:0]  ring_count;
  logic             div_start;
  logic [DIVW-1:0]  div_dividend;
  logic [DVW-1:0]   div_divisor;
  logic [DIVW-1:0]  div_quotient;
  div_status_t      div_status;

  logic signed [RAW_W:0] raw_ext;
  logic [SW-1:0]         clamped;
  logic [SW-1:0]         quotient_mean;
  logic [CMPW-1:0]       mean_cmp;
  mode_t                 mode_next;
  logic [SCALEDW-1:0]    scaled;
  logic                  out_load;

  // Clamp the reading: zero or negative gives zero, RAW_MAX and above saturate.
  always_comb begin
    raw_ext = (RAW_W + 1)'(raw_sample);
    if (raw_ext <= 0) begin
      clamped = '0;
    end else if (raw_ext >= $signed((RAW_W + 1)'(RAW_MAX))) begin
      clamped = SW'(RAW_MAX);
    end else begin
      clamped = SW'(raw_sample[RAW_W-1:0]);
    end
  end

  aarm_ring #(
    .WINDOW (WINDOW),
    .SW     (SW),
    .CNTW   (CNTW),
    .SUMW   (SUMW)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .update (ring_update),
    .sample (sample),
    .sum    (ring_sum),
    .count  (ring_count)
  );

  assign ring_update = (state == S_UPDATE);

  // The divider forms sum / count; the count is at least one once the sample is stored.
  assign div_start    = (state == S_MEAN_GO);
  assign div_dividend = DIVW'(ring_sum);
  assign div_divisor  = DVW'(ring_count);

  aarm_div #(
    .DIVW (DIVW),
    .DVW  (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_status)
  );

  // (mean * ref + RAW_MAX/2) / RAW_MAX through the reciprocal. Zero maps to zero
  // and full scale to exactly the reference without a special case.
  assign scaled = SCALEDW'(numerator) * SCALEDW'(RECIP);

  // Hysteresis: in a fault state only the clear threshold is checked, and in
  // normal the low threshold wins over the high one. The unused code acts as
  // normal.
  always_comb begin
    quotient_mean = SW'(div_quotient);
    mean_cmp      = CMPW'(quotient_mean);
    case (range_mode)
      MODE_LOW: begin
        mode_next = (mean_cmp > CMPW'(low_clear_level)) ? MODE_NORMAL : MODE_LOW;
      end
      MODE_HIGH: begin
        mode_next = (mean_cmp < CMPW'(high_clear_level)) ? MODE_NORMAL : MODE_HIGH;
      end
      default: begin
        if (mean_cmp < CMPW'(low_enter_level)) begin
          mode_next = MODE_LOW;
        end else if (mean_cmp > CMPW'(high_enter_level)) begin
          mode_next = MODE_HIGH;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
    endcase
  end

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign out_load  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_enter_level      <= LOW_ENTER_RESET;
      low_clear_level      <= LOW_CLEAR_RESET;
      high_enter_level     <= HIGH_ENTER_RESET;
      high_clear_level     <= HIGH_CLEAR_RESET;
      reference_millivolts <= REF_MV_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_ENTER:  low_enter_level      <= cfg_data[LEVEL_W-1:0];
        REG_LOW_CLEAR:  low_clear_level      <= cfg_data[LEVEL_W-1:0];
        REG_HIGH_ENTER: high_enter_level     <= cfg_data[LEVEL_W-1:0];
        REG_HIGH_CLEAR: high_clear_level     <= cfg_data[LEVEL_W-1:0];
        REG_REF_MV:     reference_millivolts <= cfg_data[REF_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register. The result is loaded once the previous
  // one has been taken, so one finished item may wait while the next runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      range_mode <= MODE_NORMAL;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_OUTPUT && out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_MEAN_GO;
        end
        S_MEAN_GO: begin
          state <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_status.done) begin
            range_mode <= mode_next;
            state      <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          state <= S_CONVERT;
        end
        S_CONVERT: begin
          state <= S_OUTPUT;
        end
        S_OUTPUT: begin
          if (out_load) begin
            mean_value      <= MEAN_W'(mean);
            mean_millivolts <= millivolts;
            range_status    <= range_mode;
            out_of_range    <= (range_mode != MODE_NORMAL);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      sample <= clamped;
    end
    if (state == S_MEAN_WAIT && div_status.done) begin
      mean <= quotient_mean;
    end
    if (state == S_SCALE) begin
      product <= PRODW'(mean) * PRODW'(reference_millivolts);
    end
    if (state == S_ROUND) begin
      numerator <= NUMW'(product) + HALF_SCALE;
    end
    if (state == S_CONVERT) begin
      millivolts <= MV_W'(scaled[SCALEDW-1:RECIP_SHIFT]);
    end
  end

endmodule

[src/aarm_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Divides the running sum by the fill count to form the mean; uses aarm_pkg.
module aarm_div #(
  parameter int unsigned DIVW = 26,
  parameter int unsigned DVW  = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DIVW-1:0]           dividend,
  input  logic [DVW-1:0]            divisor,
  output logic [DIVW-1:0]           quotient,
  output aarm_pkg::div_status_t     status
);
  import aarm_pkg::*;

  localparam int unsigned STEPW = (DIVW > 1) ? $clog2(DIVW) : 1;

  logic [DIVW-1:0]  quo;
  logic [DVW:0]     rem;
  logic [DVW-1:0]   dvs;
  logic [STEPW-1:0] step;
  logic             busy;
  logic             done;

  logic [DVW:0]     trial;
  logic             fits;
  logic [DVW:0]     rem_next;

  always_comb begin
    trial    = {rem[DVW-1:0], quo[DIVW-1]};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? (trial - {1'b0, dvs}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEPW'(DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVW-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

[src/aarm_ring.sv]
// Sample ring memory with write pointer, fill count and running sum.
// Synchronous memory with a registered read; uses aarm_pkg.
module aarm_ring #(
  parameter int unsigned WINDOW = aarm_pkg::WINDOW_DEFAULT,
  parameter int unsigned SW     = 12,
  parameter int unsigned CNTW   = 4,
  parameter int unsigned SUMW   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            update,
  input  logic [SW-1:0]   sample,
  output logic [SUMW-1:0] sum,
  output logic [CNTW-1:0] count
);
  import aarm_pkg::*;

  localparam int unsigned SLOTW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SW-1:0]    mem [WINDOW];
  logic [SW-1:0]    rd_data;
  logic [SLOTW-1:0] slot;
  logic [SUMW-1:0]  running_sum;
  logic [CNTW-1:0]  fill_count;
  logic             full;

  assign full = (fill_count == CNTW'(WINDOW));

  // The entry at the write pointer is read every cycle; it is only used once
  // the ring is full, so every entry read then has been written before.
  always_ff @(posedge clk) begin
    rd_data <= mem[slot];
    if (update) begin
      mem[slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= '0;
      running_sum <= '0;
      fill_count  <= '0;
    end else if (update) begin
      slot <= (slot == SLOTW'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (full) begin
        running_sum <= running_sum - SUMW'(rd_data) + SUMW'(sample);
      end else begin
        running_sum <= running_sum + SUMW'(sample);
        fill_count  <= fill_count + 1'b1;
      end
    end
  end

  assign sum   = running_sum;
  assign count = fill_count;

endmodule

[bench/tb_adc_average_range_monitor.sv]
`timescale 1ns / 1ps
// Self-checking testbench for adc_average_range_monitor: a directed table, then phased random readings.
// Needs aarm_pkg and the block's RTL; results are checked against a filter model here or a typed row.
module tb_adc_average_range_monitor;
  import aarm_pkg::*;

  localparam int AVG_DEPTH       = int'(WINDOW_DEFAULT);
  localparam int FULL_SCALE      = int'(RAW_MAX_DEFAULT);
  localparam int SUM_W           = MEAN_W + $clog2(AVG_DEPTH);
  localparam int COUNT_W         = $clog2(AVG_DEPTH + 1);
  localparam int SLOT_W          = $clog2(AVG_DEPTH);
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 120;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int REPORT_LIMIT    = 10;

  // One result item as the block presents it.
  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [MV_W-1:0]   mv;
    mode_t             status;
    logic              oor;
  } avg_result_t;

  // One row of the directed table. Rows with typed set carry a hand-written result.
  typedef struct {
    logic signed [RAW_W-1:0] raw;
    bit                      typed;
    avg_result_t             res;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [RAW_W-1:0]     raw_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [MEAN_W-1:0]           mean_value;
  logic [MV_W-1:0]             mean_millivolts;
  logic [STATUS_W-1:0]         range_status;
  logic                        out_of_range;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DAT_W-1:0]        cfg_data = '0;

  adc_average_range_monitor u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_sample      (raw_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mean_value      (mean_value),
    .mean_millivolts (mean_millivolts),
    .range_status    (range_status),
    .out_of_range    (out_of_range),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the configuration registers and of the filter and range state.
  logic [LEVEL_W-1:0] low_enter_lvl;
  logic [LEVEL_W-1:0] low_clear_lvl;
  logic [LEVEL_W-1:0] high_enter_lvl;
  logic [LEVEL_W-1:0] high_clear_lvl;
  logic [REF_W-1:0]   full_scale_mv;
  logic [MEAN_W-1:0]  hist [AVG_DEPTH];
  logic [SUM_W-1:0]   hist_sum;
  logic [COUNT_W-1:0] hist_count;
  logic [SLOT_W-1:0]  hist_slot;
  mode_t              monitor_mode;

  avg_result_t avg_expected [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // Idle controls, switched per phase so that some phases run with no gaps at all.
  bit          in_busy = 1'b1;
  bit          out_busy = 1'b1;
  int          stall_left = 0;

  // Random walk used to steer the mean toward interesting levels.
  int          walk_target = 0;
  int          walk_left = 0;

  function void reset_predictor();
    low_enter_lvl  = LOW_ENTER_RESET;
    low_clear_lvl  = LOW_CLEAR_RESET;
    high_enter_lvl = HIGH_ENTER_RESET;
    high_clear_lvl = HIGH_CLEAR_RESET;
    full_scale_mv  = REF_MV_RESET;
    foreach (hist[i]) hist[i] = '0;
    hist_sum     = '0;
    hist_count   = '0;
    hist_slot    = '0;
    monitor_mode = MODE_NORMAL;
  endfunction

  // Register writes are masked to the register's width; unused indexes change nothing.
  function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_LOW_ENTER:  low_enter_lvl  = data[LEVEL_W-1:0];
      REG_LOW_CLEAR:  low_clear_lvl  = data[LEVEL_W-1:0];
      REG_HIGH_ENTER: high_enter_lvl = data[LEVEL_W-1:0];
      REG_HIGH_CLEAR: high_clear_lvl = data[LEVEL_W-1:0];
      REG_REF_MV:     full_scale_mv  = data[REF_W-1:0];
      default: ;
    endcase
  endfunction

  // Clamp the reading, push it into the averaging ring, and work out the mean, its value in
  // millivolts and the next range status.
  function avg_result_t predict_reading(logic signed [RAW_W-1:0] raw);
    int                reading;
    int unsigned       scaled;
    logic [MEAN_W-1:0] clamped;
    logic [MEAN_W-1:0] mean;
    avg_result_t       res;
    reading = raw;
    if (reading <= 0) clamped = '0;
    else if (reading >= FULL_SCALE) clamped = MEAN_W'(FULL_SCALE);
    else clamped = MEAN_W'(reading);

    // While the ring fills, the count grows; once full, the oldest sample leaves the sum.
    if (hist_count < AVG_DEPTH) hist_count = hist_count + 1'b1;
    else hist_sum = hist_sum - hist[hist_slot];
    hist[hist_slot] = clamped;
    hist_sum        = hist_sum + clamped;
    hist_slot       = (hist_slot == AVG_DEPTH - 1) ? '0 : hist_slot + 1'b1;
    mean            = MEAN_W'(hist_sum / hist_count);

    // Zero and full scale map exactly; everything else rounds half up.
    if (mean == 0) scaled = 0;
    else if (mean >= FULL_SCALE) scaled = full_scale_mv;
    else scaled = (mean * full_scale_mv + FULL_SCALE / 2) / FULL_SCALE;

    // Hysteresis: faults are entered and left through separate strict thresholds.
    case (monitor_mode)
      MODE_LOW: begin
        if (mean > low_clear_lvl) monitor_mode = MODE_NORMAL;
      end
      MODE_HIGH: begin
        if (mean < high_clear_lvl) monitor_mode = MODE_NORMAL;
      end
      default: begin
        if (mean < low_enter_lvl) monitor_mode = MODE_LOW;
        else if (mean > high_enter_lvl) monitor_mode = MODE_HIGH;
        else monitor_mode = MODE_NORMAL;
      end
    endcase

    res.mean   = mean;
    res.mv     = MV_W'(scaled);
    res.status = monitor_mode;
    res.oor    = (monitor_mode != MODE_NORMAL);
    return res;
  endfunction

  function void add_row(logic signed [RAW_W-1:0] raw, bit typed = 1'b0, int mean = 0,
                        int mv = 0, mode_t status = MODE_NORMAL);
    stim_row_t row;
    row.raw        = raw;
    row.typed      = typed;
    row.res.mean   = MEAN_W'(mean);
    row.res.mv     = MV_W'(mv);
    row.res.status = status;
    row.res.oor    = (status != MODE_NORMAL);
    directed_rows.push_back(row);
  endfunction

  // Mostly back-to-back or short gaps, with the odd long one.
  function int pick_gap(bit busy);
    int roll;
    roll = $urandom_range(0, 99);
    if (!busy || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Readings follow a wandering target so the mean settles near levels long enough to cross
  // thresholds both ways; a share of the readings is raw noise or out of range.
  function logic signed [RAW_W-1:0] next_random_reading();
    int roll;
    int lvl;
    int noise;
    if (walk_left == 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        case ($urandom_range(0, 3))
          0: lvl = low_enter_lvl;
          1: lvl = low_clear_lvl;
          2: lvl = high_enter_lvl;
          default: lvl = high_clear_lvl;
        endcase
        noise = $urandom_range(0, 80);
        walk_target = lvl + noise - 40;
      end else if (roll < 50) begin
        walk_target = ($urandom_range(0, 1) != 0) ? FULL_SCALE : 0;
      end else begin
        walk_target = $urandom_range(0, FULL_SCALE);
      end
      walk_left = $urandom_range(4, 24);
    end
    walk_left = walk_left - 1;
    roll = $urandom_range(0, 99);
    if (roll < 8) return RAW_W'($urandom);
    if (roll < 12) return RAW_W'(-int'($urandom_range(1, 32768)));
    if (roll < 16) return RAW_W'($urandom_range(FULL_SCALE, 32767));
    noise = $urandom_range(0, 60);
    return RAW_W'(walk_target + noise - 30);
  endfunction

  function void report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
  endfunction

  // Offer one item, hold it until taken, and record what it should produce. Valid is only
  // dropped when a gap is wanted, so it never toggles within one step.
  task automatic send_reading(input stim_row_t row);
    int          gap;
    avg_result_t predicted;
    gap = pick_gap(in_busy);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    raw_sample = row.raw;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_reading(row.raw);
    avg_expected.push_back(row.typed ? row.res : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_config(idx, data);
  endtask

  // Stop offering items and let every outstanding result come out before touching registers.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (avg_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The first phases pin the extremes; later ones draw thresholds with proper hysteresis
  // most of the time and arbitrary (possibly crossed) ones otherwise.
  task automatic configure_phase(input int phase);
    int lo_enter;
    int lo_clear;
    int hi_enter;
    int hi_clear;
    case (phase)
      0: begin
        write_reg(REG_LOW_ENTER, '0);
        write_reg(REG_LOW_CLEAR, '0);
        write_reg(REG_HIGH_ENTER, '0);
        write_reg(REG_HIGH_CLEAR, '0);
        write_reg(REG_REF_MV, '0);
      end
      1: begin
        // Upper data bit set on the 12-bit levels: it must be dropped.
        write_reg(REG_LOW_ENTER, '1);
        write_reg(REG_LOW_CLEAR, '1);
        write_reg(REG_HIGH_ENTER, '1);
        write_reg(REG_HIGH_CLEAR, '1);
        write_reg(REG_REF_MV, '1);
      end
      2: begin
        write_reg(REG_LOW_ENTER, CFG_DAT_W'(LOW_ENTER_RESET));
        write_reg(REG_LOW_CLEAR, CFG_DAT_W'(LOW_CLEAR_RESET));
        write_reg(REG_HIGH_ENTER, CFG_DAT_W'(HIGH_ENTER_RESET));
        write_reg(REG_HIGH_CLEAR, CFG_DAT_W'(HIGH_CLEAR_RESET));
        write_reg(REG_REF_MV, CFG_DAT_W'(1));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          write_reg(REG_LOW_ENTER, CFG_DAT_W'($urandom));
          write_reg(REG_LOW_CLEAR, CFG_DAT_W'($urandom));
          write_reg(REG_HIGH_ENTER, CFG_DAT_W'($urandom));
          write_reg(REG_HIGH_CLEAR, CFG_DAT_W'($urandom));
        end else begin
          lo_enter = $urandom_range(0, 1500);
          lo_clear = lo_enter + $urandom_range(0, 400);
          hi_clear = $urandom_range(2500, 3900);
          hi_enter = hi_clear + $urandom_range(0, 195);
          write_reg(REG_LOW_ENTER, CFG_DAT_W'(lo_enter));
          write_reg(REG_LOW_CLEAR, CFG_DAT_W'(lo_clear));
          write_reg(REG_HIGH_ENTER, CFG_DAT_W'(hi_enter));
          write_reg(REG_HIGH_CLEAR, CFG_DAT_W'(hi_clear));
        end
        if (phase == 3) write_reg(REG_REF_MV, CFG_DAT_W'(5000));
        else if ($urandom_range(0, 7) == 0) write_reg(REG_REF_MV, CFG_DAT_W'($urandom));
        else write_reg(REG_REF_MV, CFG_DAT_W'($urandom_range(1, 5000)));
      end
    endcase
    // Writes to indexes past the last register must leave everything as it was.
    if (phase % 2 == 1)
      write_reg(CFG_IDX_W'(REG_REF_MV + $urandom_range(1, 3)), CFG_DAT_W'($urandom));
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // The receiver stalls now and then; about one stall in ten is a long one.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (rst || !out_busy || $urandom_range(0, 99) < 70) begin
      out_stall = 1'b0;
    end else begin
      out_stall  = 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 3);
    end
  end

  // Every accepted result is compared with the oldest expected one.
  always @(posedge clk) begin : check_results
    avg_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (avg_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result mean=%0d mv=%0d status=%0d flag=%0b",
                                  mean_value, mean_millivolts, range_status, out_of_range));
      end else begin
        want = avg_expected.pop_front();
        if (mean_value !== want.mean || mean_millivolts !== want.mv ||
            range_status !== want.status || out_of_range !== want.oor)
          report_mismatch($sformatf(
            "expected mean=%0d mv=%0d status=%0d flag=%0b, got mean=%0d mv=%0d status=%0d flag=%0b",
            want.mean, want.mv, want.status, want.oor,
            mean_value, mean_millivolts, range_status, out_of_range));
      end
    end
  end

  // A run that stops moving items on any channel for too long has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : drive
    stim_row_t row;
    reset_predictor();

    // Directed table, run with the reset configuration. Zero and negative readings clamp
    // to 0 and keep the ring's mean at 0 in low fault; eight full-scale or over-range
    // readings push the mean to full scale, which reads exactly the reference and enters
    // high fault. Mid-range bit patterns follow, then eight non-positive readings empty the
    // mean again.
    add_row(16'sh8000, 1'b1, 0, 0, MODE_LOW);
    add_row(16'sh0000, 1'b1, 0, 0, MODE_LOW);
    add_row(-16'sd1,   1'b1, 0, 0, MODE_LOW);
    add_row(16'sd4095);
    add_row(16'sd4096);
    add_row(16'sh7FFF);
    add_row(16'sd12345);
    add_row(16'sd5000);
    add_row(16'sd4095);
    add_row(16'sh7FFE);
    add_row(16'sd4095, 1'b1, 4095, int'(REF_MV_RESET), MODE_HIGH);
    add_row(16'sd1);
    add_row(16'sd4094);
    add_row(16'sh0AAA);
    add_row(16'sh0555);
    add_row(16'sh5555);
    add_row(-16'sd1);
    add_row(16'sh8000);
    add_row(16'sh0000);
    add_row(16'shAAAA);
    add_row(16'sh8001);
    add_row(16'sh0000);
    add_row(-16'sd2);
    add_row(16'sh0000, 1'b1, 0, 0, MODE_LOW);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) send_reading(directed_rows[i]);
    wait_idle();

    // Random phases, each under its own register setting. Every fourth phase runs without
    // gaps on either side so the block is exercised at full rate as well.
    for (int phase = 0; phase < PHASES; phase++) begin
      in_busy  = (phase % 4 != 3);
      out_busy = (phase % 4 != 3);
      configure_phase(phase);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        row.raw   = next_random_reading();
        row.typed = 1'b0;
        row.res   = '0;
        send_reading(row);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && avg_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
